// ===== rtl/core/tcce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

    // field widths
    localparam int COLS_W   = 10;
    localparam int ROWS_W   = 9;
    localparam int BLINK_W  = 16;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int OP_W     = 2;
    localparam int NUM_OPS  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    // register limits and reset values
    localparam logic [COLS_W-1:0]  MAX_COLS       = 10'd512;
    localparam logic [ROWS_W-1:0]  MAX_ROWS       = 9'd256;
    localparam logic [COLS_W-1:0]  RST_NUM_COLS   = 10'd80;
    localparam logic [ROWS_W-1:0]  RST_NUM_ROWS   = 9'd25;
    localparam logic [BLINK_W-1:0] RST_BLINK_PER  = 16'd50;

    // tab stops every TAB_WIDTH columns (power of two)
    localparam int TAB_WIDTH = 8;
    localparam logic [COLS_W-1:0] TAB_STEP = COLS_W'(TAB_WIDTH);

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes with special handling
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // input word kinds
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // drawing commands; the value is also the slot index in a packet mask
    typedef enum logic [OP_W-1:0] {
        OP_ERASE  = 2'd0,
        OP_GLYPH  = 2'd1,
        OP_SCROLL = 2'd2,
        OP_CURSOR = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS     = 2'd0,
        REG_NUM_ROWS     = 2'd1,
        REG_BLINK_PERIOD = 2'd2
    } reg_idx_t;

    // all drawing commands caused by one input word
    typedef struct packed {
        logic [NUM_OPS-1:0] mask;
        logic [COL_W-1:0]   erase_col;
        logic [ROW_W-1:0]   erase_row;
        logic [COL_W-1:0]   glyph_col;
        logic [ROW_W-1:0]   glyph_row;
        logic [CHAR_W-1:0]  glyph_code;
        logic [ROW_W-1:0]   scroll_row;
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
    } pkt_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== rtl/core/tcce_front.sv =====
// Front end: accepts input words, holds cursor and blink state and the
// configuration registers, and turns each word into a command packet. Uses tcce_pkg.
module tcce_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcce_pkg::CHAR_W-1:0]     s_tdata,
    input  logic                            s_tuser,
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  tcce_pkg::fifo_status_t          q_status,
    output logic                            q_push,
    output tcce_pkg::pkt_t                  q_pkt
);
    import tcce_pkg::*;

    logic [COLS_W-1:0]  num_cols_reg;
    logic [ROWS_W-1:0]  num_rows_reg;
    logic [BLINK_W-1:0] blink_period_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               shown_reg, shown_next;
    logic [BLINK_W-1:0] blink_reg, blink_next;

    logic [COLS_W-1:0]  eff_cols;
    logic [ROWS_W-1:0]  eff_rows;
    logic [BLINK_W-1:0] period;
    logic [BLINK_W:0]   blink_inc;
    logic               toggle;
    logic [COLS_W-1:0]  col_ext;
    logic [COLS_W-1:0]  col_inc;
    logic [COLS_W-1:0]  tab_stop;
    logic [COLS_W-1:0]  new_col;
    logic [ROWS_W-1:0]  new_row;
    logic               glyph_en;
    logic               scroll_en;
    logic [COL_W-1:0]   glyph_col;
    logic [CHAR_W-1:0]  glyph_code;
    logic               accept;
    pkt_t               pkt;

    // out-of-range registers clamp to the legal range
    always_comb
    begin
        eff_cols = num_cols_reg;
        if (num_cols_reg == '0)
            eff_cols = COLS_W'(1);
        else if (num_cols_reg > MAX_COLS)
            eff_cols = MAX_COLS;
        eff_rows = num_rows_reg;
        if (num_rows_reg == '0)
            eff_rows = ROWS_W'(1);
        else if (num_rows_reg > MAX_ROWS)
            eff_rows = MAX_ROWS;
        period = (blink_period_reg == '0) ? BLINK_W'(1) : blink_period_reg;
    end

    // blink counter step
    assign blink_inc = {1'b0, blink_reg} + (BLINK_W+1)'(1);
    assign toggle    = blink_inc >= {1'b0, period};

    // candidate cursor columns
    assign col_ext  = {1'b0, col_reg};
    assign col_inc  = col_ext + COLS_W'(1);
    assign tab_stop = col_ext - (col_ext % TAB_STEP) + TAB_STEP;

    // character movement and glyph drawing
    always_comb
    begin
        new_col    = col_ext;
        new_row    = {1'b0, row_reg};
        glyph_en   = 1'b0;
        glyph_col  = col_reg;
        glyph_code = s_tdata;
        case (s_tdata)
            CH_LF:
            begin
                new_col = '0;
                new_row = new_row + ROWS_W'(1);
            end
            CH_CR:
            begin
                new_col = '0;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    new_col    = col_ext - COLS_W'(1);
                    glyph_en   = 1'b1;
                    glyph_col  = col_reg - COL_W'(1);
                    glyph_code = CH_SPACE;
                end
            end
            CH_TAB:
            begin
                if (tab_stop >= eff_cols)
                begin
                    new_col = '0;
                    new_row = new_row + ROWS_W'(1);
                end
                else
                    new_col = tab_stop;
            end
            default:
            begin
                glyph_en = 1'b1;
                if (col_inc >= eff_cols)
                begin
                    new_col = '0;
                    new_row = new_row + ROWS_W'(1);
                end
                else
                    new_col = col_inc;
            end
        endcase
        // past the bottom: one scroll, cursor clamps to the last row
        scroll_en = new_row >= eff_rows;
        if (scroll_en)
            new_row = eff_rows - ROWS_W'(1);
    end

    // packet and next state for the current word
    always_comb
    begin
        pkt            = '0;
        pkt.erase_col  = col_reg;
        pkt.erase_row  = row_reg;
        pkt.glyph_col  = glyph_col;
        pkt.glyph_row  = row_reg;
        pkt.glyph_code = glyph_code;
        pkt.scroll_row = ROW_W'(eff_rows - ROWS_W'(1));
        col_next       = col_reg;
        row_next       = row_reg;
        shown_next     = shown_reg;
        blink_next     = blink_reg;
        if (s_tuser == CMD_TICK)
        begin
            pkt.cursor_col = col_reg;
            pkt.cursor_row = row_reg;
            if (toggle)
            begin
                pkt.mask[OP_ERASE]  = shown_reg;
                pkt.mask[OP_CURSOR] = !shown_reg;
                shown_next          = !shown_reg;
                blink_next          = '0;
            end
            else
                blink_next = blink_inc[BLINK_W-1:0];
        end
        else
        begin
            col_next             = new_col[COL_W-1:0];
            row_next             = new_row[ROW_W-1:0];
            pkt.cursor_col       = new_col[COL_W-1:0];
            pkt.cursor_row       = new_row[ROW_W-1:0];
            pkt.mask[OP_ERASE]   = shown_reg;
            pkt.mask[OP_GLYPH]   = glyph_en;
            pkt.mask[OP_SCROLL]  = scroll_en;
            pkt.mask[OP_CURSOR]  = 1'b1;
            shown_next           = 1'b1;
            blink_next           = '0;
        end
    end

    // handshake toward the queue
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (pkt.mask != '0);
    assign q_pkt    = pkt;

    // cursor and blink state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            shown_reg <= 1'b1;
            blink_reg <= '0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            shown_reg <= shown_next;
            blink_reg <= blink_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg     <= RST_NUM_COLS;
            num_rows_reg     <= RST_NUM_ROWS;
            blink_period_reg <= RST_BLINK_PER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_COLS:     num_cols_reg     <= cfg_wdata[COLS_W-1:0];
                REG_NUM_ROWS:     num_rows_reg     <= cfg_wdata[ROWS_W-1:0];
                REG_BLINK_PERIOD: blink_period_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // a character packet always ends by drawing the cursor
    a_char_draws_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == CMD_CHAR) |-> (q_push && q_pkt.mask[OP_CURSOR]))
        else $error("character word without draw cursor");

    // after a character the cursor row lies on screen
    a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == CMD_CHAR) |=> ({1'b0, row_reg} < eff_rows))
        else $error("cursor row left the screen after a character");

endmodule

// ===== rtl/core/tcce_fifo.sv =====
// Short command packet queue between the front and back ends.
// Uses tcce_pkg for the packet type and depth.
module tcce_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tcce_pkg::pkt_t         push_pkt,
    input  logic                   pop,
    output tcce_pkg::pkt_t         head_pkt,
    output tcce_pkg::fifo_status_t status
);
    import tcce_pkg::*;

    pkt_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_pkt     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // packet storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_pkt;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!status.empty))
        else $error("pop from an empty queue");

endmodule

// ===== rtl/core/tcce_back.sv =====
// Back end: takes command packets from the queue and sends their drawing
// commands out one word a cycle while m_tready is high. Uses tcce_pkg.
module tcce_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcce_pkg::fifo_status_t          q_status,
    input  tcce_pkg::pkt_t                  q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcce_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [tcce_pkg::OP_W-1:0]       m_tuser,
    output logic                            m_tlast
);
    import tcce_pkg::*;

    pkt_t               pkt_reg, pkt_next;
    logic [NUM_OPS-1:0] rem_reg, rem_next;
    logic [NUM_OPS-1:0] rem_after;
    op_t                cur_op;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [CHAR_W-1:0]  glyph_code;
    logic               fire;
    logic               load;

    // lowest pending command goes out first
    always_comb
    begin
        if (rem_reg[OP_ERASE])
            cur_op = OP_ERASE;
        else if (rem_reg[OP_GLYPH])
            cur_op = OP_GLYPH;
        else if (rem_reg[OP_SCROLL])
            cur_op = OP_SCROLL;
        else
            cur_op = OP_CURSOR;
    end

    assign rem_after = rem_reg & (rem_reg - NUM_OPS'(1));

    // cell fields of the current command
    always_comb
    begin
        cell_col   = '0;
        cell_row   = '0;
        glyph_code = '0;
        unique case (cur_op)
            OP_ERASE:
            begin
                cell_col = pkt_reg.erase_col;
                cell_row = pkt_reg.erase_row;
            end
            OP_GLYPH:
            begin
                cell_col   = pkt_reg.glyph_col;
                cell_row   = pkt_reg.glyph_row;
                glyph_code = pkt_reg.glyph_code;
            end
            OP_SCROLL:
            begin
                cell_row = pkt_reg.scroll_row;
            end
            OP_CURSOR:
            begin
                cell_col = pkt_reg.cursor_col;
                cell_row = pkt_reg.cursor_row;
            end
            default: ;
        endcase
    end

    assign m_tvalid = rem_reg != '0;
    assign m_tlast  = rem_after == '0;
    assign m_tuser  = cur_op;
    assign m_tdata  = OUT_DATA_W'({glyph_code, cell_row, cell_col});

    // next packet is fetched as the last command of this one leaves, or while no command is pending
    assign fire  = m_tvalid && m_tready;
    assign load  = !m_tvalid || (fire && m_tlast);
    assign q_pop = load && !q_status.empty;

    always_comb
    begin
        pkt_next = pkt_reg;
        rem_next = rem_reg;
        if (q_pop)
        begin
            pkt_next = q_head;
            rem_next = q_head.mask;
        end
        else if (fire)
            rem_next = rem_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    // a packet runs without gaps once started
    a_packet_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !m_tlast) |=> m_tvalid)
        else $error("gap inside a command packet");

    // commands of one packet come out in rising op order
    a_op_order: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !m_tlast) |=> (m_tuser > $past(m_tuser)))
        else $error("command order broken inside a packet");

endmodule

// ===== rtl/core/text_console_cursor_engine_top.sv =====
// Text console cursor engine. Input words are character bytes (s_tuser low,
// s_tdata the byte) or timer ticks (s_tuser high). Each word turns into a
// packet of cell drawing commands: erase cursor, draw glyph, scroll up, draw
// cursor, sent one word per cycle on the output stream while m_tready is
// high, with m_tlast on the final command of the packet. An input word is
// taken every cycle while the two-entry packet queue has room; the output
// side sends 0 to 4 words per input word, so sustained rate is set by the
// output stream: a character gives 1 to 4 commands, a toggling tick 1, and
// a tick that does not toggle the cursor gives no output. With the back end
// idle, a word passes the queue entry and the back-end packet register
// before its first command is offered. Configuration (num_cols, num_rows,
// blink_period) is written through cfg_we/cfg_index/cfg_wdata; the user
// must write it only while the engine is idle, as the block does not check.
//
// Top level; instantiates tcce_front, tcce_fifo and tcce_back, uses tcce_pkg.
module text_console_cursor_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcce_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic                            s_tuser,   // [0] command
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcce_pkg::OUT_DATA_W-1:0] m_tdata,   // [8:0] cell_col, [16:9] cell_row,
                                                        // [24:17] glyph_code, [31:25] zero
    output logic [tcce_pkg::OP_W-1:0]       m_tuser,   // [1:0] op
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tcce_pkg::*;

    fifo_status_t q_status;
    logic         q_push;
    logic         q_pop;
    pkt_t         q_pkt;
    pkt_t         q_head;

    // classification and cursor state
    tcce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_pkt     (q_pkt)
    );

    // packet queue
    tcce_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (q_pkt),
        .pop      (q_pop),
        .head_pkt (q_head),
        .status   (q_status)
    );

    // command sequencer
    tcce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
